FILE: src/cpts_pkg.sv
// Package for the counter-priority task scheduler: sizes, field widths, codes.
// No dependencies; used by the top level by scoped names.
package cpts_pkg;

    localparam int MAX_TASKS  = 16;
    localparam int SLICE_BITS = 8;

    localparam int IDX_W   = $clog2(MAX_TASKS);
    localparam int CNT_W   = $clog2(MAX_TASKS + 1);
    localparam int TCNT_W  = 5;
    localparam int CMP_W   = (CNT_W > TCNT_W) ? CNT_W : TCNT_W;
    localparam int MASK_W  = 16;
    localparam int PRIO_W  = 8;
    localparam int TASK_W  = 4;
    localparam int SLOUT_W = 8;

    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CMP_W-1:0]      t_cnt;
    typedef logic [SLICE_BITS-1:0] t_slice;
    typedef logic [PRIO_W-1:0]     t_prio;

    // input item kinds (tuser)
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    // configuration register indexes
    localparam logic CFG_TASK_COUNT = 1'b0;
    localparam logic CFG_RUNNABLE   = 1'b1;

endpackage

FILE: src/cpts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies. Read during write to the same address returns old data.
module cpts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/counter_priority_task_scheduler.sv
// Top level of the counter-priority task scheduler (largest slice first).
// Depends on cpts_pkg and two cpts_ram instances (slice counters, priorities).
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+-------------------------------------------
//  s (in)   | in  | i_s_tvalid / o_s_tready | tuser: kind; tdata: task_index, priority
//  m (out)  | out | o_m_tvalid / i_m_tready | tdata: running_task, slice_left, switched,
//           |     |                         |        reloaded
//  cfg      | in  | i_cfg_we (no wait)      | i_cfg_addr: register, i_cfg_wdata: value
//
// One item at a time. A load, or a tick that keeps the running task, passes
// through S_CUR and S_OUT to the output register. A tick that picks again scans
// the slice RAM once per slot in use; if no slot qualifies, a reload pass
// through the priority RAM and a second scan follow, and a final slice read
// (S_FIN_RD, S_FIN) fetches the result. The slice RAM read port sets the pace.
// Synchronous active-low reset; RAM contents start as zero through per-entry
// valid bits, no clearing pass. A stalled result sits in the output register
// while the next item is taken; a new result waits only for that register.
module counter_priority_task_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [3:0] task_index, [11:4] priority_value
    input  logic        i_s_tuser,   // [0] kind
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [3:0] running_task, [11:4] slice_left,
                                     // [12] switched, [13] reloaded
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CUR,
        S_SCAN,
        S_RELOAD,
        S_FIN_RD,
        S_FIN,
        S_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic [cpts_pkg::TCNT_W-1:0] r_task_count;
    logic [cpts_pkg::MASK_W-1:0] r_runnable;

    // item context
    logic             r_kind;
    cpts_pkg::t_idx   r_cur;
    cpts_pkg::t_idx   r_before;
    logic             r_reloaded;
    logic             r_second;

    // scan / sweep pipeline
    cpts_pkg::t_cnt   r_idx;
    logic             r_pend;
    cpts_pkg::t_idx   r_pend_idx;
    logic             r_best_fnd;
    cpts_pkg::t_idx   r_best_idx;
    cpts_pkg::t_slice r_best_val;

    // valid bits standing in for the zero reset of both RAMs
    logic [cpts_pkg::MAX_TASKS-1:0] r_slice_vld;
    logic [cpts_pkg::MAX_TASKS-1:0] r_prio_vld;
    logic                           r_svld_q;
    logic                           r_pvld_q;

    // result staging and output register
    cpts_pkg::t_slice r_res_slice;
    logic             r_out_valid;
    logic [15:0]      r_out_data;

    // RAM ports
    cpts_pkg::t_idx   w_slice_raddr;
    cpts_pkg::t_slice w_slice_rdata;
    logic             w_slice_we;
    cpts_pkg::t_idx   w_slice_waddr;
    cpts_pkg::t_slice w_slice_wdata;
    logic             w_prio_we;
    cpts_pkg::t_idx   w_prio_waddr;
    cpts_pkg::t_prio  w_prio_rdata;

    logic                           w_accept;
    cpts_pkg::t_cnt                 w_nslots;
    logic [cpts_pkg::MAX_TASKS-1:0] w_run_vec;
    cpts_pkg::t_slice               w_slice_val;
    cpts_pkg::t_slice               w_prio_val;
    cpts_pkg::t_slice               w_dec;
    logic                           w_more;
    logic                           w_out_free;

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    // slots in use, saturated at the table size
    assign w_nslots = (cpts_pkg::CMP_W'(r_task_count) > cpts_pkg::CMP_W'(cpts_pkg::MAX_TASKS))
                    ? cpts_pkg::CMP_W'(cpts_pkg::MAX_TASKS)
                    : cpts_pkg::CMP_W'(r_task_count);

    assign w_run_vec   = cpts_pkg::MAX_TASKS'(r_runnable);
    assign w_slice_val = r_svld_q ? w_slice_rdata : '0;
    assign w_prio_val  = r_pvld_q ? cpts_pkg::SLICE_BITS'(w_prio_rdata) : '0;
    assign w_dec       = w_slice_val - 1'b1;
    assign w_more      = (r_idx < w_nslots);

    // slice RAM read address: scan index while scanning, else the running task
    always_comb begin
        if (r_state == S_SCAN) begin
            w_slice_raddr = r_idx[cpts_pkg::IDX_W-1:0];
        end else begin
            w_slice_raddr = r_cur;
        end
    end

    // slice RAM write: decrement of the running task, or reload from priority
    always_comb begin
        w_slice_we    = 1'b0;
        w_slice_waddr = r_cur;
        w_slice_wdata = w_dec;
        if (r_state == S_CUR && r_kind == cpts_pkg::KIND_TICK
                && r_cur != '0 && w_slice_val != '0) begin
            w_slice_we = 1'b1;
        end else if (r_state == S_RELOAD && r_pend) begin
            w_slice_we    = 1'b1;
            w_slice_waddr = r_pend_idx;
            w_slice_wdata = w_prio_val;
        end
    end

    // priority load, ignored for slots beyond the table
    assign w_prio_waddr = cpts_pkg::IDX_W'(i_s_tdata[3:0]);
    assign w_prio_we    = w_accept && i_s_tuser == cpts_pkg::KIND_LOAD
                       && (cpts_pkg::CMP_W'(i_s_tdata[3:0])
                           < cpts_pkg::CMP_W'(cpts_pkg::MAX_TASKS));

    cpts_ram #(
        .WIDTH (cpts_pkg::SLICE_BITS),
        .DEPTH (cpts_pkg::MAX_TASKS)
    ) u_slice_ram (
        .i_clk   (i_clk),
        .i_we    (w_slice_we),
        .i_waddr (w_slice_waddr),
        .i_wdata (w_slice_wdata),
        .i_raddr (w_slice_raddr),
        .o_rdata (w_slice_rdata)
    );

    cpts_ram #(
        .WIDTH (cpts_pkg::PRIO_W),
        .DEPTH (cpts_pkg::MAX_TASKS)
    ) u_prio_ram (
        .i_clk   (i_clk),
        .i_we    (w_prio_we),
        .i_waddr (w_prio_waddr),
        .i_wdata (i_s_tdata[11:4]),
        .i_raddr (r_idx[cpts_pkg::IDX_W-1:0]),
        .o_rdata (w_prio_rdata)
    );

    always_ff @(posedge i_clk) begin
        // valid bit of the entry being read travels with its data
        r_svld_q <= r_slice_vld[w_slice_raddr];
        r_pvld_q <= r_prio_vld[r_idx[cpts_pkg::IDX_W-1:0]];

        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_task_count <= cpts_pkg::TCNT_W'(2);
            r_runnable   <= '1;
            r_cur        <= '0;
            r_slice_vld  <= '0;
            r_prio_vld   <= '0;
            r_out_valid  <= 1'b0;
            r_pend       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    cpts_pkg::CFG_TASK_COUNT: r_task_count <= i_cfg_wdata[cpts_pkg::TCNT_W-1:0];
                    cpts_pkg::CFG_RUNNABLE:   r_runnable   <= i_cfg_wdata;
                    default: ;
                endcase
            end

            if (w_slice_we) begin
                r_slice_vld[w_slice_waddr] <= 1'b1;
            end
            if (w_prio_we) begin
                r_prio_vld[w_prio_waddr] <= 1'b1;
            end

            // output register: a new result wins over the drain of the old one
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_kind     <= i_s_tuser;
                        r_before   <= r_cur;
                        r_reloaded <= 1'b0;
                        r_second   <= 1'b0;
                        r_state    <= S_CUR;
                    end
                end

                S_CUR: begin
                    r_idx      <= '0;
                    r_pend     <= 1'b0;
                    r_best_fnd <= 1'b0;
                    r_best_val <= '0;
                    if (r_kind == cpts_pkg::KIND_LOAD) begin
                        r_res_slice <= w_slice_val;
                        r_state     <= S_OUT;
                    end else if (r_cur == '0 || w_slice_val == '0 || w_dec == '0) begin
                        r_state <= S_SCAN;
                    end else begin
                        r_res_slice <= w_dec;
                        r_state     <= S_OUT;
                    end
                end

                S_SCAN: begin
                    // compare the entry read last cycle; strict > keeps lowest index
                    if (r_pend && w_run_vec[r_pend_idx] && w_slice_val > r_best_val) begin
                        r_best_val <= w_slice_val;
                        r_best_idx <= r_pend_idx;
                        r_best_fnd <= 1'b1;
                    end
                    r_pend     <= w_more;
                    r_pend_idx <= r_idx[cpts_pkg::IDX_W-1:0];
                    if (w_more) begin
                        r_idx <= r_idx + 1'b1;
                    end else if (!r_pend) begin
                        r_idx <= '0;
                        if (r_best_fnd) begin
                            r_cur   <= r_best_idx;
                            r_state <= S_FIN_RD;
                        end else if (!r_second) begin
                            r_reloaded <= 1'b1;
                            r_second   <= 1'b1;
                            r_state    <= S_RELOAD;
                        end else begin
                            r_cur   <= '0;
                            r_state <= S_FIN_RD;
                        end
                    end
                end

                S_RELOAD: begin
                    // priority read last cycle is written to the slice RAM now
                    r_pend     <= w_more;
                    r_pend_idx <= r_idx[cpts_pkg::IDX_W-1:0];
                    if (w_more) begin
                        r_idx <= r_idx + 1'b1;
                    end else if (!r_pend) begin
                        r_idx      <= '0;
                        r_best_fnd <= 1'b0;
                        r_best_val <= '0;
                        r_state    <= S_SCAN;
                    end
                end

                S_FIN_RD: begin
                    r_state <= S_FIN;
                end

                S_FIN: begin
                    r_res_slice <= w_slice_val;
                    r_state     <= S_OUT;
                end

                S_OUT: begin
                    if (w_out_free) begin
                        r_out_data  <= {2'b00, r_reloaded, (r_cur != r_before),
                                        cpts_pkg::SLOUT_W'(r_res_slice),
                                        cpts_pkg::TASK_W'(r_cur)};
                        r_state     <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

FILE: sim/schedule_checker.sv
// Result checker for the task scheduler: tracks its own copy of slices, priorities
// and registers from the input and config channels, and compares every result.
// Depends on cpts_pkg.
module schedule_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,   // [3:0] task_index, [11:4] priority_value
    input  logic        i_s_tuser,   // [0] kind
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,   // [3:0] running_task, [11:4] slice_left,
                                     // [12] switched, [13] reloaded
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    output int          o_pending,
    output int          o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0] pad;
        logic       reloaded;
        logic       switched;
        logic [7:0] slice_left;
        logic [3:0] running_task;
    } t_sched_out;

    cpts_pkg::t_slice slices [cpts_pkg::MAX_TASKS];
    cpts_pkg::t_prio  prios  [cpts_pkg::MAX_TASKS];
    cpts_pkg::t_idx   running;
    logic [4:0]       task_count;
    logic [15:0]      runnable;

    t_sched_out  expected_picks [$];
    t_sched_out  seen;
    t_sched_out  want;
    int          mismatch_count;

    function automatic int slots_used();
        return (task_count > cpts_pkg::MAX_TASKS) ? cpts_pkg::MAX_TASKS : int'(task_count);
    endfunction

    // largest nonzero runnable slice, lowest slot on ties; MAX_TASKS if none
    function automatic int best_slot();
        int               best;
        cpts_pkg::t_slice top_val;
        best    = cpts_pkg::MAX_TASKS;
        top_val = '0;
        for (int i = 0; i < slots_used(); i++) begin
            if (runnable[i] && slices[i] > top_val) begin
                top_val = slices[i];
                best    = i;
            end
        end
        return best;
    endfunction

    // returns 1 when the slices had to be refilled from the priorities
    function automatic logic repick();
        int   best;
        logic refill;
        refill = 1'b0;
        best   = best_slot();
        if (best >= cpts_pkg::MAX_TASKS) begin
            for (int i = 0; i < slots_used(); i++)
                slices[i] = cpts_pkg::t_slice'(prios[i]);
            refill = 1'b1;
            best   = best_slot();
        end
        if (best >= cpts_pkg::MAX_TASKS)
            best = 0;
        running = cpts_pkg::t_idx'(best);
        return refill;
    endfunction

    function automatic t_sched_out advance_schedule(logic kind, cpts_pkg::t_idx idx,
                                                    cpts_pkg::t_prio value);
        t_sched_out     res;
        cpts_pkg::t_idx was;
        logic           refill;
        res    = '0;
        was    = running;
        refill = 1'b0;
        if (kind == cpts_pkg::KIND_LOAD) begin
            prios[idx] = value;
        end else if (running == '0 || slices[running] == '0) begin
            refill = repick();
        end else begin
            slices[running] = slices[running] - 1'b1;
            if (slices[running] == '0)
                refill = repick();
        end
        res.running_task = running;
        res.slice_left   = slices[running];
        res.switched     = (running != was);
        res.reloaded     = refill;
        return res;
    endfunction

    function automatic void note_failure(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t ns: %s", $realtime, msg);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (slices[i]) begin
                slices[i] = '0;
                prios[i]  = '0;
            end
            running        = '0;
            task_count     = 5'd2;
            runnable       = 16'hFFFF;
            mismatch_count = 0;
            expected_picks.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == cpts_pkg::CFG_TASK_COUNT)
                    task_count = i_cfg_wdata[4:0];
                else
                    runnable = i_cfg_wdata;
            end
            if (i_s_tvalid && i_s_tready)
                expected_picks.push_back(
                    advance_schedule(i_s_tuser, i_s_tdata[3:0], i_s_tdata[11:4]));
            if (i_m_tvalid && i_m_tready) begin
                seen = t_sched_out'(i_m_tdata);
                if (expected_picks.size() == 0) begin
                    note_failure($sformatf(
                        "unexpected result task=%0d slice=%0d sw=%0b rl=%0b",
                        seen.running_task, seen.slice_left, seen.switched,
                        seen.reloaded));
                end else begin
                    want = expected_picks.pop_front();
                    if (seen.running_task !== want.running_task
                        || seen.slice_left !== want.slice_left
                        || seen.switched !== want.switched
                        || seen.reloaded !== want.reloaded)
                        note_failure($sformatf(
                            {"mismatch: expected task=%0d slice=%0d sw=%0b rl=%0b, ",
                             "got task=%0d slice=%0d sw=%0b rl=%0b"},
                            want.running_task, want.slice_left, want.switched,
                            want.reloaded, seen.running_task, seen.slice_left,
                            seen.switched, seen.reloaded));
                end
            end
        end
        o_pending    <= expected_picks.size();
        o_mismatches <= mismatch_count;
    end

endmodule

FILE: sim/tb_counter_priority_task_scheduler.sv
// Testbench top for counter_priority_task_scheduler: clock, reset, stimulus, verdict.
// Depends on cpts_pkg, the scheduler RTL and schedule_checker.
module tb_counter_priority_task_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT    = 3000;  // cycles with no transfer on either stream
    localparam int HOLD_CYCLES   = 300;   // long result back-pressure stretch
    localparam int DRAIN_CYCLES  = 64;    // longer than the worst-case result latency
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PHASES = 24;
    localparam int PHASE_ITEMS   = 52;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        cfg_we;
    logic        cfg_addr;
    logic [15:0] cfg_wdata;

    int pending;
    int mismatches;
    int quiet_cycles = 0;
    int hold_asks    = 0;   // bumped by stimulus, served by the result side
    int hold_seen    = 0;
    bit calm         = 1'b0; // both sides stop idling while set

    counter_priority_task_scheduler dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    schedule_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // One input transfer. An optional gap with tvalid low comes first; after the
    // transfer tvalid stays up so back-to-back items never drop it in one step.
    task automatic send_item(logic kind, cpts_pkg::t_idx idx, cpts_pkg::t_prio value);
        if (!calm && $urandom_range(99) < 36) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0000, value, idx};
        do @(posedge clk); while (!s_tready);
    endtask

    // tick: index and value ride along as noise, the block ignores them
    task automatic tick_item();
        send_item(cpts_pkg::KIND_TICK, cpts_pkg::t_idx'($urandom),
                  cpts_pkg::t_prio'($urandom));
    endtask

    // Mostly short priorities so slices drain and reloads come often; now and
    // then a long one, and some zeros so whole-zero reloads fall back to idle.
    task automatic random_item();
        int              pick;
        cpts_pkg::t_prio value;
        pick = $urandom_range(63);
        if (pick == 0)
            value = cpts_pkg::t_prio'($urandom_range(128, 255));
        else if (pick < 6)
            value = '0;
        else
            value = cpts_pkg::t_prio'($urandom_range(1, 7));
        if ($urandom_range(99) < 30)
            send_item(cpts_pkg::KIND_LOAD, cpts_pkg::t_idx'($urandom_range(15)), value);
        else
            tick_item();
    endtask

    // Registers change only with nothing in flight: drain all results, then a
    // short settle before the two writes.
    task automatic reconfigure(logic [4:0] count, logic [15:0] mask);
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= cpts_pkg::CFG_TASK_COUNT;
        cfg_wdata <= {11'd0, count};
        @(posedge clk);
        cfg_addr  <= cpts_pkg::CFG_RUNNABLE;
        cfg_wdata <= mask;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // result side: random back-pressure, calm stretches, one long hold-off
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 36);
            end
        end
    end

    // watchdog: any transfer on either stream restarts the count
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("FAIL counter_priority_task_scheduler");
                $finish;
            end
        end
    end

    initial begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= cpts_pkg::KIND_TICK;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_addr  <= cpts_pkg::CFG_TASK_COUNT;
        cfg_wdata <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed, reset config (2 slots, all runnable) ---
        tick_item();                          // all zero: reload, still idle
        send_item(cpts_pkg::KIND_LOAD, 4'd1, 8'd3);
        send_item(cpts_pkg::KIND_LOAD, 4'd15, 8'd255);  // top index, top priority
        send_item(cpts_pkg::KIND_LOAD, 4'd0, 8'd0);
        tick_item();                          // reload, switch to slot 1
        tick_item();
        tick_item();
        tick_item();                          // drained: reload, keep slot 1

        // count above the slot range saturates; slot 15 masked off
        reconfigure(5'd31, 16'h7FFF);
        tick_item();

        // running slot now beyond the count: still counts down, then idle
        reconfigure(5'd1, 16'hFFFF);
        tick_item();
        tick_item();

        // no slots in use: nothing to scan, pick falls to idle
        reconfigure(5'd0, 16'hFFFF);
        tick_item();

        // idle itself holding a slice: picked, and a tick while idle re-picks
        reconfigure(5'd16, 16'h0001);
        send_item(cpts_pkg::KIND_LOAD, 4'd15, 8'd0);
        send_item(cpts_pkg::KIND_LOAD, 4'd0, 8'd9);
        tick_item();
        tick_item();

        reconfigure(5'd16, 16'hFFFF);
        tick_item();

        // --- random phases over a spread of register settings ---
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p % 8)
                0: reconfigure(5'd16, 16'hFFFF);
                1: reconfigure(5'd0, 16'($urandom));
                2: reconfigure(5'd31, 16'($urandom));
                3: reconfigure(5'd1, 16'hFFFF);
                4: reconfigure(5'd2, 16'h0000);
                default: reconfigure(5'($urandom_range(1, 16)), 16'($urandom));
            endcase
            calm = (p == 8);          // one long stretch without idling
            if (p == 13)
                hold_asks++;          // result side stalls, input backs up
            repeat (PHASE_ITEMS) random_item();
        end
        calm = 1'b0;

        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS counter_priority_task_scheduler");
        else
            $display("FAIL counter_priority_task_scheduler");
        $finish;
    end

endmodule
